// ===== rtl/rf64hg_pkg.sv =====
package rf64hg_pkg;

   localparam int unsigned BYTES_W    = 63;
   localparam int unsigned RIFF_W     = 64;
   localparam int unsigned FRAMES_W   = 61;
   localparam int unsigned CHAN_W     = 14;
   localparam int unsigned RATE_W     = 32;
   localparam int unsigned WORD_W     = 32;
   localparam int unsigned IDX_W      = 5;

   localparam int unsigned DIV_BITS   = 63;
   localparam int unsigned DIV_STEPS  = 3;
   localparam int unsigned DIV_CYCLES = DIV_BITS / DIV_STEPS;
   localparam int unsigned DCNT_W     = $clog2(DIV_CYCLES);

   localparam logic [IDX_W-1:0] LAST_WORD = 5'd28;

   localparam logic [0:0] CSR_SAMP_RATE     = 1'b0;
   localparam logic [0:0] CSR_CHANNEL_COUNT = 1'b1;

   localparam logic [RATE_W-1:0] RESET_SAMP_RATE = 32'd48000;
   localparam logic [CHAN_W-1:0] RESET_CHANNELS  = 14'd2;

   localparam logic [WORD_W-1:0] TAG_RIFF = 32'h46464952;
   localparam logic [WORD_W-1:0] TAG_RF64 = 32'h34364652;
   localparam logic [WORD_W-1:0] TAG_WAVE = 32'h45564157;
   localparam logic [WORD_W-1:0] TAG_JUNK = 32'h4B4E554A;
   localparam logic [WORD_W-1:0] TAG_DS64 = 32'h34367364;
   localparam logic [WORD_W-1:0] TAG_FMT  = 32'h20746D66;
   localparam logic [WORD_W-1:0] TAG_FACT = 32'h74636166;
   localparam logic [WORD_W-1:0] TAG_DATA = 32'h61746164;
   localparam logic [WORD_W-1:0] ALL_ONES = 32'hFFFFFFFF;

   localparam logic [WORD_W-1:0] GUID_W0 = 32'h00000003;
   localparam logic [WORD_W-1:0] GUID_W1 = 32'h00100000;
   localparam logic [WORD_W-1:0] GUID_W2 = 32'hAA000080;
   localparam logic [WORD_W-1:0] GUID_W3 = 32'h719B3800;

   localparam logic [RIFF_W-1:0] RIFF_BASE = 64'd108;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_HOLD
   } front_state_type;

   typedef struct packed {
      logic [BYTES_W-1:0]  bytes;
      logic [RIFF_W-1:0]   riff;
      logic [FRAMES_W-1:0] frames;
      logic                big;
   } desc_type;

   function automatic logic [WORD_W-1:0] spk_mask(input logic [CHAN_W-1:0] chans);
      logic [WORD_W-1:0] mask;
      unique case (chans)
         14'd1:   mask = 32'h00000004;
         14'd2:   mask = 32'h00000003;
         14'd3:   mask = 32'h00000007;
         14'd4:   mask = 32'h00000033;
         14'd5:   mask = 32'h00000037;
         14'd6:   mask = 32'h0000003F;
         14'd7:   mask = 32'h0000013F;
         14'd8:   mask = 32'h0000063F;
         default: mask = 32'h00000000;
      endcase
      return mask;
   endfunction

endpackage

// ===== rtl/wav_rf64_header_generator_top.sv =====
// Float32 extensible WAVE header generator with RF64 promotion.
// req_ channel: one beat carries the audio payload byte count; the block
// answers with 29 rsp_ beats, the 116-byte header as little-endian words,
// word 0 first, tlast on word 28, tuser set when the header is RF64.
// csr_ port: index 0 writes the sample rate, index 1 the channel count;
// write only while no header is in flight.
// Flow: a request runs through a frame-count divider (three quotient
// bits per cycle), then a two-entry queue, then the output register.
// Words go out one per cycle while rsp_tready is high. req_tready is
// high only while the divider is idle, so the next request is taken and
// divided while the current header streams; headers follow back to back
// with no gap.
// Reset returns sample rate 48000 and two channels and drops any headers
// in flight. When rsp_tready is low the output register holds its beat;
// the queue takes up to two finished requests and a third waits in the
// divider with req_tready low.
module wav_rf64_header_generator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [62:0] payload_bytes, [63] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [4:0] word_index, [36:5] header_word, [39:37] zero
   output logic        rsp_tuser,   // [0] is_rf64
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import rf64hg_pkg::*;

   logic [RATE_W-1:0] samp_rate_ff;
   logic [CHAN_W-1:0] channel_count_ff;
   logic              push_valid;
   logic              push_ready;
   desc_type          push_desc;
   logic              head_valid;
   desc_type          head_desc;
   logic              pop;
   logic [IDX_W-1:0]  out_index;
   logic [WORD_W-1:0] out_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         samp_rate_ff     <= RESET_SAMP_RATE;
         channel_count_ff <= RESET_CHANNELS;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SAMP_RATE:     samp_rate_ff     <= csr_wdata;
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   rf64hg_front u_front (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_tvalid),
      .in_ready      (req_tready),
      .in_bytes      (req_tdata[BYTES_W-1:0]),
      .channel_count (channel_count_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_desc     (push_desc)
   );

   rf64hg_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_desc  (push_desc),
      .head_valid (head_valid),
      .head_desc  (head_desc),
      .pop        (pop)
   );

   rf64hg_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_desc     (head_desc),
      .pop           (pop),
      .samp_rate     (samp_rate_ff),
      .channel_count (channel_count_ff),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_index     (out_index),
      .out_word      (out_word),
      .out_big       (rsp_tuser),
      .out_last      (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, out_word, out_index};

endmodule

// ===== rtl/rf64hg_front.sv =====
module rf64hg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic [rf64hg_pkg::BYTES_W-1:0] in_bytes,
   input  logic [rf64hg_pkg::CHAN_W-1:0]  channel_count,
   output logic                          push_valid,
   input  logic                          push_ready,
   output rf64hg_pkg::desc_type          push_desc
);
   import rf64hg_pkg::*;

   front_state_type            state_ff, state_in;
   logic [DCNT_W-1:0]          cnt_ff, cnt_in;
   logic [DIV_BITS-1:0]        div_ff, div_in;
   logic [CHAN_W-1:0]          rem_ff, rem_in;
   logic [BYTES_W-1:0]         bytes_ff;
   logic [RIFF_W-1:0]          riff_ff;
   logic [CHAN_W:0]            rem_v;
   logic [DIV_BITS-1:0]        div_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
      if (in_valid && in_ready) begin
         bytes_ff <= in_bytes;
         riff_ff  <= RIFF_BASE + {1'b0, in_bytes};
      end
   end

   // restoring divide, three quotient bits per cycle
   always_comb begin
      rem_v = {1'b0, rem_ff};
      div_v = div_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         rem_v = {rem_v[CHAN_W-1:0], div_v[DIV_BITS-1]};
         div_v = {div_v[DIV_BITS-2:0], 1'b0};
         if (rem_v >= {1'b0, channel_count}) begin
            rem_v    = rem_v - {1'b0, channel_count};
            div_v[0] = 1'b1;
         end
      end
   end

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      div_in     = div_ff;
      rem_in     = rem_ff;
      in_ready   = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         FRONT_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               div_in   = {2'b00, in_bytes[BYTES_W-1:2]};
               rem_in   = '0;
               cnt_in   = '0;
               state_in = FRONT_DIVIDE;
            end
         end
         FRONT_DIVIDE: begin
            div_in = div_v;
            rem_in = rem_v[CHAN_W-1:0];
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DCNT_W'(DIV_CYCLES - 1)) begin
               state_in = FRONT_HOLD;
            end
         end
         FRONT_HOLD: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FRONT_IDLE;
            end
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   always_comb begin
      push_desc.bytes  = bytes_ff;
      push_desc.riff   = riff_ff;
      push_desc.frames = (channel_count == '0) ? '0 : div_ff[FRAMES_W-1:0];
      push_desc.big    = (riff_ff[RIFF_W-1:32] != '0) || (riff_ff[31:0] == ALL_ONES);
   end

endmodule

// ===== rtl/rf64hg_fifo.sv =====
module rf64hg_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  rf64hg_pkg::desc_type push_desc,
   output logic                 head_valid,
   output rf64hg_pkg::desc_type head_desc,
   input  logic                 pop
);
   import rf64hg_pkg::*;

   desc_type   entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_desc  = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// ===== rtl/rf64hg_back.sv =====
module rf64hg_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   input  rf64hg_pkg::desc_type           head_desc,
   output logic                           pop,
   input  logic [rf64hg_pkg::RATE_W-1:0]  samp_rate,
   input  logic [rf64hg_pkg::CHAN_W-1:0]  channel_count,
   output logic                           out_valid,
   input  logic                           out_ready,
   output logic [rf64hg_pkg::IDX_W-1:0]   out_index,
   output logic [rf64hg_pkg::WORD_W-1:0]  out_word,
   output logic                           out_big,
   output logic                           out_last
);
   import rf64hg_pkg::*;

   logic [IDX_W-1:0]  idx_ff;
   logic              valid_ff;
   logic [IDX_W-1:0]  oidx_ff;
   logic [WORD_W-1:0] oword_ff;
   logic              obig_ff;
   logic              olast_ff;
   logic [WORD_W-1:0] byte_rate_ff;
   logic [47:0]       prod;
   logic [15:0]       align;
   logic [WORD_W-1:0] word_in;
   logic              load;
   logic              big;
   logic              fact_sat;

   assign align = {channel_count, 2'b00};
   assign prod  = 48'(samp_rate) * 48'(align);
   assign big   = head_desc.big;
   assign load  = head_valid && (!valid_ff || out_ready);
   assign pop   = load && (idx_ff == LAST_WORD);

   assign fact_sat = big || (head_desc.frames[FRAMES_W-1:32] != '0) ||
                     (head_desc.frames[31:0] == ALL_ONES);

   always_comb begin
      unique case (idx_ff)
         5'd0:    word_in = big ? TAG_RF64 : TAG_RIFF;
         5'd1:    word_in = big ? ALL_ONES : head_desc.riff[31:0];
         5'd2:    word_in = TAG_WAVE;
         5'd3:    word_in = big ? TAG_DS64 : TAG_JUNK;
         5'd4:    word_in = 32'd28;
         5'd5:    word_in = big ? head_desc.riff[31:0] : '0;
         5'd6:    word_in = big ? head_desc.riff[63:32] : '0;
         5'd7:    word_in = big ? head_desc.bytes[31:0] : '0;
         5'd8:    word_in = big ? {1'b0, head_desc.bytes[62:32]} : '0;
         5'd9:    word_in = big ? head_desc.frames[31:0] : '0;
         5'd10:   word_in = big ? {3'b000, head_desc.frames[60:32]} : '0;
         5'd12:   word_in = TAG_FMT;
         5'd13:   word_in = 32'd40;
         5'd14:   word_in = {2'b00, channel_count, 16'hFFFE};
         5'd15:   word_in = samp_rate;
         5'd16:   word_in = byte_rate_ff;
         5'd17:   word_in = {16'd32, align};
         5'd18:   word_in = {16'd32, 16'd22};
         5'd19:   word_in = spk_mask(channel_count);
         5'd20:   word_in = GUID_W0;
         5'd21:   word_in = GUID_W1;
         5'd22:   word_in = GUID_W2;
         5'd23:   word_in = GUID_W3;
         5'd24:   word_in = TAG_FACT;
         5'd25:   word_in = 32'd4;
         5'd26:   word_in = fact_sat ? ALL_ONES : head_desc.frames[31:0];
         5'd27:   word_in = TAG_DATA;
         5'd28:   word_in = big ? ALL_ONES : head_desc.bytes[31:0];
         default: word_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (load) begin
            valid_ff <= 1'b1;
            idx_ff   <= (idx_ff == LAST_WORD) ? '0 : idx_ff + 1'b1;
         end else if (out_ready) begin
            valid_ff <= 1'b0;
         end
      end
      byte_rate_ff <= prod[WORD_W-1:0];
      if (load) begin
         oidx_ff  <= idx_ff;
         oword_ff <= word_in;
         obig_ff  <= big;
         olast_ff <= (idx_ff == LAST_WORD);
      end
   end

   assign out_valid = valid_ff;
   assign out_index = oidx_ff;
   assign out_word  = oword_ff;
   assign out_big   = obig_ff;
   assign out_last  = olast_ff;

endmodule

// ===== verif/wav_rf64_header_generator_top_tb.sv =====
`timescale 1ns / 1ps

module wav_rf64_header_generator_top_tb;
   import rf64hg_pkg::*;

   localparam int unsigned HEADER_WORDS = LAST_WORD + 1;
   localparam int unsigned SETTLE_CYCLES = 32;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned PHASE_ITEMS = 28;
   localparam logic [63:0] SIZE_LIMIT = 64'hFFFF_FFFE;

   typedef struct packed {
      logic [IDX_W-1:0]  word_index;
      logic [WORD_W-1:0] header_word;
      logic              is_rf64;
      logic              last_word;
   } header_beat_type;

   class header_scoreboard;
      logic [RATE_W-1:0] samp_rate;
      logic [CHAN_W-1:0] channel_count;
      header_beat_type   expected_words[$];
      int unsigned       errors;

      function new();
         samp_rate     = RESET_SAMP_RATE;
         channel_count = RESET_CHANNELS;
         errors        = 0;
      endfunction

      function void set_register(logic [0:0] index, logic [31:0] value);
         if (index == CSR_SAMP_RATE) begin
            samp_rate = value;
         end else if (index == CSR_CHANNEL_COUNT) begin
            channel_count = value[CHAN_W-1:0];
         end
      endfunction

      function logic [WORD_W-1:0] speaker_layout(logic [CHAN_W-1:0] chans);
         case (chans)
            14'd1:   return 32'h0000_0004;
            14'd2:   return 32'h0000_0003;
            14'd3:   return 32'h0000_0007;
            14'd4:   return 32'h0000_0033;
            14'd5:   return 32'h0000_0037;
            14'd6:   return 32'h0000_003F;
            14'd7:   return 32'h0000_013F;
            14'd8:   return 32'h0000_063F;
            default: return 32'h0000_0000;
         endcase
      endfunction

      function int unsigned pending();
         return expected_words.size();
      endfunction

      function void predict_header(logic [BYTES_W-1:0] payload_bytes);
         logic [63:0]       riff_len;
         logic [63:0]       frame_count;
         logic [63:0]       data_size;
         logic [15:0]       align_bytes;
         logic [WORD_W-1:0] words [HEADER_WORDS];
         logic              promoted;
         header_beat_type   beat;
         align_bytes = {channel_count, 2'b00};
         data_size   = {1'b0, payload_bytes};
         frame_count = (align_bytes == 16'd0) ? 64'd0 : data_size / {48'd0, align_bytes};
         riff_len    = RIFF_BASE + data_size;
         promoted    = riff_len > SIZE_LIMIT;
         words[0]  = promoted ? TAG_RF64 : TAG_RIFF;
         words[1]  = promoted ? ALL_ONES : riff_len[31:0];
         words[2]  = TAG_WAVE;
         words[3]  = promoted ? TAG_DS64 : TAG_JUNK;
         words[4]  = 32'd28;
         words[5]  = promoted ? riff_len[31:0] : 32'd0;
         words[6]  = promoted ? riff_len[63:32] : 32'd0;
         words[7]  = promoted ? data_size[31:0] : 32'd0;
         words[8]  = promoted ? data_size[63:32] : 32'd0;
         words[9]  = promoted ? frame_count[31:0] : 32'd0;
         words[10] = promoted ? frame_count[63:32] : 32'd0;
         words[11] = 32'd0;
         words[12] = TAG_FMT;
         words[13] = 32'd40;
         words[14] = {2'b00, channel_count, 16'hFFFE};
         words[15] = samp_rate;
         words[16] = samp_rate * {16'd0, align_bytes};
         words[17] = {16'd32, align_bytes};
         words[18] = {16'd32, 16'd22};
         words[19] = speaker_layout(channel_count);
         words[20] = GUID_W0;
         words[21] = GUID_W1;
         words[22] = GUID_W2;
         words[23] = GUID_W3;
         words[24] = TAG_FACT;
         words[25] = 32'd4;
         words[26] = (promoted || frame_count > SIZE_LIMIT) ? ALL_ONES : frame_count[31:0];
         words[27] = TAG_DATA;
         words[28] = promoted ? ALL_ONES : data_size[31:0];
         for (int k = 0; k < HEADER_WORDS; k++) begin
            beat.word_index  = IDX_W'(k);
            beat.header_word = words[k];
            beat.is_rf64     = promoted;
            beat.last_word   = (k == LAST_WORD);
            expected_words.push_back(beat);
         end
      endfunction

      function void check_beat(header_beat_type got);
         header_beat_type want;
         if (expected_words.size() == 0) begin
            $error("unexpected header beat: word_index %0d header_word %h",
                   got.word_index, got.header_word);
            errors++;
            return;
         end
         want = expected_words.pop_front();
         if (got.word_index !== want.word_index) begin
            $error("word_index: expected %0d, actual %0d", want.word_index, got.word_index);
            errors++;
         end
         if (got.header_word !== want.header_word) begin
            $error("header_word (word %0d): expected %h, actual %h",
                   want.word_index, want.header_word, got.header_word);
            errors++;
         end
         if (got.is_rf64 !== want.is_rf64) begin
            $error("is_rf64 (word %0d): expected %b, actual %b",
                   want.word_index, want.is_rf64, got.is_rf64);
            errors++;
         end
         if (got.last_word !== want.last_word) begin
            $error("last_word (word %0d): expected %b, actual %b",
                   want.word_index, want.last_word, got.last_word);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [0:0]  csr_index = CSR_SAMP_RATE;
   logic [31:0] csr_wdata = '0;

   int unsigned send_idle_pct = 17;
   int unsigned recv_idle_pct = 72;
   int unsigned cycle_count = 0;

   header_scoreboard sb = new();

   wav_rf64_header_generator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_beat({rsp_tdata[4:0], rsp_tdata[36:5], rsp_tuser, rsp_tlast});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("wav_rf64_header_generator_top verification failed");
         $finish;
      end
   end

   function automatic logic [BYTES_W-1:0] random_payload();
      logic [63:0] r;
      logic [63:0] near;
      r    = {$urandom, $urandom};
      near = 64'hFFFF_FF8E + $urandom_range(8);
      case ($urandom_range(5))
         0:       return r[62:0];
         1:       return {31'd0, r[31:0]};
         2:       return near[62:0];
         3:       return {47'd0, r[15:0]};
         4:       return {22'd0, r[40:0]};
         default: return r[62:0] >> $urandom_range(62);
      endcase
   endfunction

   task automatic send_payload(input logic [BYTES_W-1:0] payload_bytes);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, payload_bytes};
      do @(posedge clock); while (!req_tready);
      sb.predict_header(payload_bytes);
   endtask

   // drop valid and wait out every header in flight
   task automatic wait_headers_done();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [0:0] index, input logic [31:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      sb.set_register(index, value);
   endtask

   initial begin
      logic [31:0] rate_val;
      logic [31:0] chans_val;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // field extremes and the promotion boundary at reset settings
      send_payload(63'd0);
      send_payload(63'd1);
      send_payload(63'd7);
      send_payload(63'd8);
      send_payload(63'h0000_0000_FFFF_FF92);
      send_payload(63'h0000_0000_FFFF_FF93);
      send_payload(63'h0000_0000_FFFF_FFFF);
      send_payload(63'h0000_0001_0000_0000);
      send_payload(63'h7FFF_FFFF_FFFF_FFFF);
      send_payload(63'h5555_5555_5555_5555);
      send_payload(63'h2AAA_AAAA_AAAA_AAAA);
      wait_headers_done();

      // every speaker layout entry, zero channels, and one past the table
      for (int c = 0; c <= 9; c++) begin
         write_reg(CSR_CHANNEL_COUNT, c);
         send_payload(random_payload());
         wait_headers_done();
      end

      write_reg(CSR_SAMP_RATE, 32'd0);
      send_payload(63'h0000_0000_0001_0000);
      wait_headers_done();
      write_reg(CSR_SAMP_RATE, 32'hFFFF_FFFF);
      wait_headers_done();
      write_reg(CSR_CHANNEL_COUNT, 32'hFFFF_FFFF);
      send_payload(63'h7FFF_FFFF_FFFF_FFFF);
      wait_headers_done();

      for (int p = 0; p < 9; p++) begin
         case (p / 3)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 72;
            end
            1: begin
               send_idle_pct = 72;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         case (p % 3)
            0: begin
               rate_val  = $urandom;
               chans_val = $urandom_range(1, 8);
            end
            1: begin
               rate_val  = (p == 4) ? 32'd0 : 32'hFFFF_FFFF;
               chans_val = (p == 1) ? 32'd16383 : ((p == 4) ? 32'd0 : 32'd1);
            end
            default: begin
               rate_val  = $urandom_range(8000, 384000);
               chans_val = $urandom_range(0, 16383);
            end
         endcase
         chans_val = chans_val | ($urandom & 32'hFFFF_C000);
         write_reg(CSR_SAMP_RATE, rate_val);
         wait_headers_done();
         write_reg(CSR_CHANNEL_COUNT, chans_val);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (p == 1 && n == PHASE_ITEMS / 2) begin
               wait_headers_done();
            end
            send_payload(random_payload());
         end
         wait_headers_done();
      end

      wait_headers_done();
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("wav_rf64_header_generator_top verification clean");
      end else begin
         $display("wav_rf64_header_generator_top verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/rf64hg_pkg.sv
rtl/rf64hg_front.sv
rtl/rf64hg_fifo.sv
rtl/rf64hg_back.sv
rtl/wav_rf64_header_generator_top.sv
verif/wav_rf64_header_generator_top_tb.sv
